FILE: hw/rtl/psb_pkg.sv
// psb_pkg: shared field widths, status codes and the result struct of the
// priority slot buffer. No dependencies.
`timescale 1ns / 1ps

package psb_pkg;

	localparam int PRIO_IN_W = 4;
	localparam int ID_W      = 16;
	localparam int TIME_W    = 32;
	localparam int IDX_OUT_W = 3;
	localparam int FILL_W    = 4;
	localparam int STATUS_W  = 2;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t STATUS_ADDED    = 2'd0;
	localparam status_t STATUS_REJECTED = 2'd1;
	localparam status_t STATUS_TAKEN    = 2'd2;
	localparam status_t STATUS_EMPTY    = 2'd3;

	typedef struct packed {
		status_t               status;
		logic [IDX_OUT_W-1:0]  slot_index;
		logic [PRIO_IN_W-1:0]  out_priority;
		logic [ID_W-1:0]       out_id;
		logic [TIME_W-1:0]     out_time;
		logic [FILL_W-1:0]     fill_count;
	} rsp_t;

endpackage

FILE: hw/rtl/psb_slot_mem.sv
// psb_slot_mem: slot contents store (priority, id, time), one write and one
// read port, registered read data. No package dependency.
`timescale 1ns / 1ps

module psb_slot_mem #(
	parameter int DEPTH = 8,
	parameter int AW    = 3,
	parameter int DW    = 52
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_s1;

endmodule

FILE: hw/rtl/psb_ctrl.sv
// psb_ctrl: sequencer of the priority slot buffer. Holds the valid bits and
// fill count, scans the slot store and picks the free or best slot.
// Depends on psb_pkg.
`timescale 1ns / 1ps

module psb_ctrl #(
	parameter int SLOTS = 8,
	parameter int PW    = 4,
	parameter int IDX_W = 3,
	parameter int DW    = 52
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic                      action,
	input  logic [PW-1:0]             req_pr,
	input  logic [psb_pkg::ID_W-1:0]  req_id,
	input  logic [psb_pkg::TIME_W-1:0] req_time,
	output logic                      mem_wr_en,
	output logic [IDX_W-1:0]          mem_wr_addr,
	output logic [DW-1:0]             mem_wr_data,
	output logic                      mem_rd_en,
	output logic [IDX_W-1:0]          mem_rd_addr,
	input  logic [DW-1:0]             mem_rd_data,
	input  logic                      out_free,
	output logic                      rsp_load,
	output psb_pkg::rsp_t             rsp
);

	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int TW    = psb_pkg::TIME_W;
	localparam int IW    = psb_pkg::ID_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t              state_q;
	logic                action_q;
	logic [PW-1:0]       pr_q;
	logic [IW-1:0]       id_q;
	logic [TW-1:0]       time_q;
	logic [SLOTS-1:0]    valid_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    scan_cnt_q;
	logic                rd_vld_s1;
	logic [IDX_W-1:0]    rd_idx_s1;
	logic                found_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic [PW-1:0]       best_pr_q;
	logic [IW-1:0]       best_id_q;
	logic [TW-1:0]       best_time_q;

	logic                accept;
	logic                issue;
	logic                scan_end;
	logic                done_go;
	logic [PW-1:0]       d_pr;
	logic [IW-1:0]       d_id;
	logic [TW-1:0]       d_time;
	logic                cand_valid;
	logic                take_better;
	logic                add_free;
	logic                upd;
	logic [CNT_W-1:0]    count_nxt;

	assign accept    = req_valid && (state_q == ST_IDLE);
	assign req_stall = (state_q != ST_IDLE);

	assign issue       = (state_q == ST_SCAN) && (scan_cnt_q != CNT_W'(SLOTS));
	assign scan_end    = (state_q == ST_SCAN) && (scan_cnt_q == CNT_W'(SLOTS));
	assign mem_rd_en   = issue;
	assign mem_rd_addr = scan_cnt_q[IDX_W-1:0];

	assign d_pr   = mem_rd_data[DW-1 -: PW];
	assign d_id   = mem_rd_data[TW +: IW];
	assign d_time = mem_rd_data[TW-1:0];

	assign cand_valid  = valid_q[rd_idx_s1];
	// stale entries of free slots are read but never used
	assign take_better = cand_valid && (!found_q || (d_pr < best_pr_q) ||
		((d_pr == best_pr_q) && (d_time < best_time_q)));
	assign add_free    = !cand_valid && !found_q;
	assign upd         = rd_vld_s1 && (action_q ? take_better : add_free);

	assign done_go  = (state_q == ST_DONE) && out_free;
	assign rsp_load = done_go;

	assign mem_wr_en   = done_go && !action_q && found_q;
	assign mem_wr_addr = best_idx_q;
	assign mem_wr_data = {pr_q, id_q, time_q};

	always_comb begin
		rsp       = '0;
		count_nxt = count_q;
		case ({action_q, found_q})
			2'b01: begin
				count_nxt       = count_q + CNT_W'(1);
				rsp.status      = psb_pkg::STATUS_ADDED;
				rsp.slot_index  = psb_pkg::IDX_OUT_W'(best_idx_q);
			end
			2'b00: begin
				rsp.status       = psb_pkg::STATUS_REJECTED;
				rsp.out_priority = psb_pkg::PRIO_IN_W'(pr_q);
			end
			2'b11: begin
				count_nxt        = count_q - CNT_W'(1);
				rsp.status       = psb_pkg::STATUS_TAKEN;
				rsp.slot_index   = psb_pkg::IDX_OUT_W'(best_idx_q);
				rsp.out_priority = psb_pkg::PRIO_IN_W'(best_pr_q);
				rsp.out_id       = best_id_q;
				rsp.out_time     = best_time_q;
			end
			default: begin
				rsp.status = psb_pkg::STATUS_EMPTY;
			end
		endcase
		rsp.fill_count = psb_pkg::FILL_W'(count_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			valid_q    <= '0;
			count_q    <= '0;
			scan_cnt_q <= '0;
			rd_vld_s1  <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						scan_cnt_q <= '0;
						found_q    <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						scan_cnt_q <= scan_cnt_q + CNT_W'(1);
					end
					if (upd) begin
						found_q <= 1'b1;
					end
					// last read beat is compared on this same edge
					if (scan_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (done_go) begin
						if (found_q) begin
							valid_q[best_idx_q] <= !action_q;
						end
						count_q <= count_nxt;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			pr_q     <= req_pr;
			id_q     <= req_id;
			time_q   <= req_time;
		end
		if (issue) begin
			rd_idx_s1 <= mem_rd_addr;
		end
		if (upd) begin
			best_idx_q  <= rd_idx_s1;
			best_pr_q   <= d_pr;
			best_id_q   <= d_id;
			best_time_q <= d_time;
		end
	end

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'($countones(valid_q)))
		else $error("fill count out of step with valid bits");

	a_take_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(done_go && action_q && found_q) |=> !valid_q[$past(best_idx_q)])
		else $error("taken slot still marked valid");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scan_cnt_q <= CNT_W'(SLOTS))
		else $error("scan counter past last slot");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_SCAN))
		else $error("read data returned outside scan");

endmodule

FILE: hw/rtl/priority_slot_buffer.sv
// priority_slot_buffer: slot buffer that hands out requests lowest priority
// value first, then oldest time, then lowest slot.
// Depends on psb_pkg, psb_slot_mem and psb_ctrl.
//
// Usage:
//   request channel (req_valid / req_stall): action 0 adds a request
//   (request_priority, request_id, request_time) into the lowest free slot,
//   action 1 takes the best stored request. One result beat per request beat.
//   result channel (rsp_valid / rsp_stall): status, slot_index, out_priority,
//   out_id, out_time and fill_count after the item.
//   Timing: every item scans all SLOTS entries of the slot store, one read per
//   cycle through its single read port, before its result is registered; a
//   new request is taken only once the previous result has been loaded into
//   the output register.
//   The result sits in an output register; while the receiver stalls, the
//   next request is still taken and scanned, and only its final write-back
//   waits until the output register frees up.
//   Reset clears all valid bits and the fill count; slot contents are not
//   cleared, so the block is ready in the first cycle after reset.
`timescale 1ns / 1ps

module priority_slot_buffer #(
	parameter int SLOTS         = 8,
	parameter int PRIORITY_BITS = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic                               action,
	input  logic [psb_pkg::PRIO_IN_W-1:0]      request_priority,
	input  logic [psb_pkg::ID_W-1:0]           request_id,
	input  logic [psb_pkg::TIME_W-1:0]         request_time,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output psb_pkg::status_t                   status,
	output logic [psb_pkg::IDX_OUT_W-1:0]      slot_index,
	output logic [psb_pkg::PRIO_IN_W-1:0]      out_priority,
	output logic [psb_pkg::ID_W-1:0]           out_id,
	output logic [psb_pkg::TIME_W-1:0]         out_time,
	output logic [psb_pkg::FILL_W-1:0]         fill_count
);

	localparam int PW    = (PRIORITY_BITS < psb_pkg::PRIO_IN_W) ?
		PRIORITY_BITS : psb_pkg::PRIO_IN_W;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int DW    = PW + psb_pkg::ID_W + psb_pkg::TIME_W;

	logic              mem_wr_en;
	logic [IDX_W-1:0]  mem_wr_addr;
	logic [DW-1:0]     mem_wr_data;
	logic              mem_rd_en;
	logic [IDX_W-1:0]  mem_rd_addr;
	logic [DW-1:0]     mem_rd_data;
	logic              out_free;
	logic              rsp_load;
	psb_pkg::rsp_t     rsp_nxt;
	psb_pkg::rsp_t     rsp_q;
	logic              rsp_valid_q;

	psb_slot_mem #(
		.DEPTH (SLOTS),
		.AW    (IDX_W),
		.DW    (DW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	psb_ctrl #(
		.SLOTS (SLOTS),
		.PW    (PW),
		.IDX_W (IDX_W),
		.DW    (DW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.action      (action),
		.req_pr      (request_priority[PW-1:0]),
		.req_id      (request_id),
		.req_time    (request_time),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data),
		.out_free    (out_free),
		.rsp_load    (rsp_load),
		.rsp         (rsp_nxt)
	);

	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = rsp_q.status;
	assign slot_index   = rsp_q.slot_index;
	assign out_priority = rsp_q.out_priority;
	assign out_id       = rsp_q.out_id;
	assign out_time     = rsp_q.out_time;
	assign fill_count   = rsp_q.fill_count;

endmodule

FILE: tb/sv/tb_priority_slot_buffer.sv
// tb_priority_slot_buffer: self-checking testbench for priority_slot_buffer.
// A directed table and a long random run of add and take requests go through a
// slot-level predictor; needs psb_pkg and the priority_slot_buffer RTL.
`timescale 1ns / 1ps

module tb_priority_slot_buffer;

	localparam int CLK_PERIOD     = 8;
	localparam int SLOTS          = 8;
	localparam int PRIO_BITS      = 4;
	localparam int SEGMENTS       = 17;
	localparam int SEG_ITEMS      = 100;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 60;

	localparam logic ACT_ADD  = 1'b0;
	localparam logic ACT_TAKE = 1'b1;

	localparam logic [psb_pkg::PRIO_IN_W-1:0] PRIO_MASK =
		psb_pkg::PRIO_IN_W'((1 << PRIO_BITS) - 1);
	localparam psb_pkg::rsp_t NO_RSP = '0;

	typedef struct packed {
		logic                          act;
		logic [psb_pkg::PRIO_IN_W-1:0] prio;
		logic [psb_pkg::ID_W-1:0]      id;
		logic [psb_pkg::TIME_W-1:0]    tm;
		logic                          fixed;
		psb_pkg::rsp_t                 want;
	} stim_row_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          req_valid = 1'b0;
	logic                          req_stall;
	logic                          action = ACT_ADD;
	logic [psb_pkg::PRIO_IN_W-1:0] request_priority = '0;
	logic [psb_pkg::ID_W-1:0]      request_id = '0;
	logic [psb_pkg::TIME_W-1:0]    request_time = '0;
	logic                          rsp_valid;
	logic                          rsp_stall = 1'b0;
	psb_pkg::status_t              status;
	logic [psb_pkg::IDX_OUT_W-1:0] slot_index;
	logic [psb_pkg::PRIO_IN_W-1:0] out_priority;
	logic [psb_pkg::ID_W-1:0]      out_id;
	logic [psb_pkg::TIME_W-1:0]    out_time;
	logic [psb_pkg::FILL_W-1:0]    fill_count;

	// slot image kept by the predictor
	logic                          held_valid [SLOTS];
	logic [psb_pkg::PRIO_IN_W-1:0] held_prio [SLOTS];
	logic [psb_pkg::ID_W-1:0]      held_id [SLOTS];
	logic [psb_pkg::TIME_W-1:0]    held_time [SLOTS];
	int                            held_count = 0;

	psb_pkg::rsp_t awaited_outcomes [$];

	int  errors = 0;
	int  n_adds = 0;
	int  n_rejected = 0;
	int  n_takes = 0;
	int  n_empty = 0;
	int  n_results = 0;
	int  idle_cycles = 0;
	int  stall_left = 0;
	int  gap_pct = 25;
	bit  calm = 1'b0;

	// first take on empty, extremes, a full buffer with priority and time ties
	stim_row_t directed_rows [0:24] = '{
		'{ACT_TAKE, 4'd0,  16'h0000, 32'h0000_0000, 1'b1,
			'{psb_pkg::STATUS_EMPTY, 3'd0, 4'd0, 16'h0000, 32'h0000_0000, 4'd0}},
		'{ACT_ADD,  4'd15, 16'hffff, 32'hffff_ffff, 1'b1,
			'{psb_pkg::STATUS_ADDED, 3'd0, 4'd0, 16'h0000, 32'h0000_0000, 4'd1}},
		'{ACT_ADD,  4'd0,  16'h0000, 32'h0000_0000, 1'b1,
			'{psb_pkg::STATUS_ADDED, 3'd1, 4'd0, 16'h0000, 32'h0000_0000, 4'd2}},
		'{ACT_TAKE, 4'd0,  16'h0000, 32'h0000_0000, 1'b1,
			'{psb_pkg::STATUS_TAKEN, 3'd1, 4'd0, 16'h0000, 32'h0000_0000, 4'd1}},
		'{ACT_TAKE, 4'd0,  16'h0000, 32'h0000_0000, 1'b1,
			'{psb_pkg::STATUS_TAKEN, 3'd0, 4'd15, 16'hffff, 32'hffff_ffff, 4'd0}},
		'{ACT_TAKE, 4'd0,  16'h0000, 32'h0000_0000, 1'b1,
			'{psb_pkg::STATUS_EMPTY, 3'd0, 4'd0, 16'h0000, 32'h0000_0000, 4'd0}},
		'{ACT_ADD,  4'd5,  16'h1111, 32'd100,       1'b0, NO_RSP},
		'{ACT_ADD,  4'd5,  16'h2222, 32'd50,        1'b0, NO_RSP},
		'{ACT_ADD,  4'd5,  16'h3333, 32'd50,        1'b0, NO_RSP},
		'{ACT_ADD,  4'd5,  16'h4444, 32'd7,         1'b0, NO_RSP},
		'{ACT_ADD,  4'd3,  16'h5555, 32'd200,       1'b0, NO_RSP},
		'{ACT_ADD,  4'd5,  16'h6666, 32'd7,         1'b0, NO_RSP},
		'{ACT_ADD,  4'd3,  16'h7777, 32'd200,       1'b0, NO_RSP},
		'{ACT_ADD,  4'd5,  16'h8888, 32'h8000_0000, 1'b0, NO_RSP},
		'{ACT_ADD,  4'd9,  16'haaaa, 32'd1,         1'b1,
			'{psb_pkg::STATUS_REJECTED, 3'd0, 4'd9, 16'h0000, 32'h0000_0000, 4'd8}},
		'{ACT_ADD,  4'd15, 16'hffff, 32'hffff_ffff, 1'b1,
			'{psb_pkg::STATUS_REJECTED, 3'd0, 4'd15, 16'h0000, 32'h0000_0000, 4'd8}},
		'{ACT_TAKE, 4'd0,  16'h0000, 32'h0000_0000, 1'b0, NO_RSP},
		'{ACT_TAKE, 4'd15, 16'hffff, 32'hffff_ffff, 1'b0, NO_RSP},
		'{ACT_TAKE, 4'd0,  16'h0000, 32'h0000_0000, 1'b0, NO_RSP},
		'{ACT_TAKE, 4'd0,  16'h0000, 32'h0000_0000, 1'b0, NO_RSP},
		'{ACT_TAKE, 4'd0,  16'h0000, 32'h0000_0000, 1'b0, NO_RSP},
		'{ACT_TAKE, 4'd0,  16'h0000, 32'h0000_0000, 1'b0, NO_RSP},
		'{ACT_TAKE, 4'd0,  16'h0000, 32'h0000_0000, 1'b0, NO_RSP},
		'{ACT_TAKE, 4'd0,  16'h0000, 32'h0000_0000, 1'b0, NO_RSP},
		'{ACT_TAKE, 4'd0,  16'h0000, 32'h0000_0000, 1'b1,
			'{psb_pkg::STATUS_EMPTY, 3'd0, 4'd0, 16'h0000, 32'h0000_0000, 4'd0}}
	};

	priority_slot_buffer #(
		.SLOTS         (SLOTS),
		.PRIORITY_BITS (PRIO_BITS)
	) u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.action           (action),
		.request_priority (request_priority),
		.request_id       (request_id),
		.request_time     (request_time),
		.rsp_valid        (rsp_valid),
		.rsp_stall        (rsp_stall),
		.status           (status),
		.slot_index       (slot_index),
		.out_priority     (out_priority),
		.out_id           (out_id),
		.out_time         (out_time),
		.fill_count       (fill_count)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// lowest free slot on add; lowest priority, then oldest time, then lowest slot on take
	task automatic serve_request(input logic act,
			input logic [psb_pkg::PRIO_IN_W-1:0] prio,
			input logic [psb_pkg::ID_W-1:0] id, input logic [psb_pkg::TIME_W-1:0] tm,
			output psb_pkg::rsp_t res);
		logic [psb_pkg::PRIO_IN_W-1:0] p;
		int best;
		res = '0;
		p = prio & PRIO_MASK;
		best = -1;
		if (act == ACT_ADD) begin
			n_adds++;
			for (int i = 0; i < SLOTS; i++)
				if (best < 0 && !held_valid[i])
					best = i;
			if (best < 0) begin
				n_rejected++;
				res.status = psb_pkg::STATUS_REJECTED;
				res.out_priority = p;
			end else begin
				held_valid[best] = 1'b1;
				held_prio[best] = p;
				held_id[best] = id;
				held_time[best] = tm;
				held_count++;
				res.status = psb_pkg::STATUS_ADDED;
				res.slot_index = psb_pkg::IDX_OUT_W'(best);
			end
		end else begin
			n_takes++;
			for (int i = 0; i < SLOTS; i++)
				if (held_valid[i] && (best < 0 || held_prio[i] < held_prio[best] ||
						(held_prio[i] == held_prio[best] && held_time[i] < held_time[best])))
					best = i;
			if (best < 0) begin
				n_empty++;
				res.status = psb_pkg::STATUS_EMPTY;
			end else begin
				held_valid[best] = 1'b0;
				held_count--;
				res.status = psb_pkg::STATUS_TAKEN;
				res.slot_index = psb_pkg::IDX_OUT_W'(best);
				res.out_priority = held_prio[best];
				res.out_id = held_id[best];
				res.out_time = held_time[best];
			end
		end
		res.fill_count = psb_pkg::FILL_W'(held_count);
	endtask

	// drives one request beat, holds it until taken and returns its prediction
	task automatic send_request(input logic act,
			input logic [psb_pkg::PRIO_IN_W-1:0] prio,
			input logic [psb_pkg::ID_W-1:0] id, input logic [psb_pkg::TIME_W-1:0] tm,
			output psb_pkg::rsp_t res);
		req_valid <= 1'b1;
		action <= act;
		request_priority <= prio;
		request_id <= id;
		request_time <= tm;
		do @(posedge clk); while (req_stall !== 1'b0);
		serve_request(act, prio, id, tm, res);
	endtask

	task automatic maybe_gap();
		if (!calm && $urandom_range(99, 0) < gap_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(14, 1)) @(posedge clk);
		end
	endtask

	task automatic report_mismatch(input string field, input longint unsigned got,
			input longint unsigned want);
		if (errors < MAX_REPORTS)
			$display("[%0t] result %0d: %s is %0h, expected %0h", $realtime, n_results,
				field, got, want);
		errors++;
	endtask

	// result side: stall in bursts, free-running in between and in the quiet tail
	always @(posedge clk) begin
		if (calm) begin
			rsp_stall <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
		end else if ($urandom_range(2, 0) == 0) begin
			rsp_stall <= 1'b1;
			stall_left = $urandom_range(14, 1) - 1;
		end else begin
			rsp_stall <= 1'b0;
			stall_left = $urandom_range(30, 1) - 1;
		end
	end

	always @(posedge clk) begin
		psb_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			n_results++;
			if (awaited_outcomes.size() == 0) begin
				report_mismatch("beat with nothing pending, status", status, 0);
			end else begin
				want = awaited_outcomes.pop_front();
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (slot_index !== want.slot_index)
					report_mismatch("slot_index", slot_index, want.slot_index);
				if (out_priority !== want.out_priority)
					report_mismatch("out_priority", out_priority, want.out_priority);
				if (out_id !== want.out_id)
					report_mismatch("out_id", out_id, want.out_id);
				if (out_time !== want.out_time)
					report_mismatch("out_time", out_time, want.out_time);
				if (fill_count !== want.fill_count)
					report_mismatch("fill_count", fill_count, want.fill_count);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d results pending",
					idle_cycles, awaited_outcomes.size());
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		psb_pkg::rsp_t res;
		int add_pct;
		int narrow_pct;
		logic act;
		logic [psb_pkg::PRIO_IN_W-1:0] prio;
		logic [psb_pkg::TIME_W-1:0] tm;

		for (int i = 0; i < SLOTS; i++)
			held_valid[i] = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			maybe_gap();
			send_request(directed_rows[r].act, directed_rows[r].prio, directed_rows[r].id,
				directed_rows[r].tm, res);
			awaited_outcomes.push_back(directed_rows[r].fixed ? directed_rows[r].want : res);
		end

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			// drain completely once, in the middle of the run
			if (seg == SEGMENTS / 2) begin
				req_valid <= 1'b0;
				do @(posedge clk); while (awaited_outcomes.size() != 0);
			end
			calm = (seg >= SEGMENTS - 2);
			case (seg % 4)
				0: add_pct = 85;
				1: add_pct = 50;
				2: add_pct = 30;
				default: add_pct = 65;
			endcase
			narrow_pct = (seg % 3 == 0) ? 20 : 70;
			case ($urandom_range(2, 0))
				0: gap_pct = 0;
				1: gap_pct = 10;
				default: gap_pct = 35;
			endcase
			for (int k = 0; k < SEG_ITEMS; k++) begin
				act = ($urandom_range(99, 0) < add_pct) ? ACT_ADD : ACT_TAKE;
				// narrow ranges make priority and time ties common
				prio = ($urandom_range(99, 0) < narrow_pct)
					? psb_pkg::PRIO_IN_W'($urandom_range(3, 0))
					: psb_pkg::PRIO_IN_W'($urandom_range(15, 0));
				tm = ($urandom_range(99, 0) < narrow_pct)
					? psb_pkg::TIME_W'($urandom_range(15, 0))
					: psb_pkg::TIME_W'($urandom());
				maybe_gap();
				send_request(act, prio, psb_pkg::ID_W'($urandom_range(65535, 0)), tm, res);
				awaited_outcomes.push_back(res);
			end
		end

		req_valid <= 1'b0;
		do @(posedge clk); while (awaited_outcomes.size() != 0);
		repeat (SLOTS + 12) @(posedge clk);

		$display("ran %0d requests: %0d adds, %0d of them rejected on a full buffer",
			n_adds + n_takes, n_adds, n_rejected);
		$display("%0d takes, %0d of them on an empty buffer; %0d result beats checked",
			n_takes, n_empty, n_results);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", errors);
			$display("simulation failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/psb_pkg.sv
hw/rtl/psb_slot_mem.sv
hw/rtl/psb_ctrl.sv
hw/rtl/priority_slot_buffer.sv
tb/sv/tb_priority_slot_buffer.sv
